[design/lpss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpss_pkg
// Shared types and constants for the LED panel scroll and scan engine.
// ----------------------------------------------------------------------------
package lpss_pkg;

    localparam int PANEL_COLUMNS = 8;
    localparam int ROWS          = 8;
    localparam int MAX_TEXT      = 80;
    localparam int TEXT_W        = 7;
    localparam int PAUSE_END     = 71;
    localparam int ROW_W         = PANEL_COLUMNS * 8;
    localparam int WORDS         = 2 * PANEL_COLUMNS;
    localparam int WCNT_W        = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [1:0] {
        OP_REFRESH = 2'd0,
        OP_SCROLL  = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch_rows;
        logic do_scroll;
        logic do_clear;
        logic load_word;
        logic word_odd;
        logic last_word;
        logic shift_hold;
        logic load_status;
        logic step_row;
    } dp_cmd_t;

endpackage
`default_nettype wire

[design/lpss_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpss_datapath
// Frame rows, scroll/text state, refresh hold registers and result register.
// ----------------------------------------------------------------------------
module lpss_datapath
    import lpss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [63:0]       glyph,
    input  wire logic              cfg_we,
    input  wire logic [TEXT_W-1:0] cfg_wdata,
    output logic [1:0]             row_select,
    output logic [15:0]            shift_word,
    output logic [TEXT_W-1:0]      char_index,
    output logic                   last
);

    // Row r holds all columns of that row, column 0 in the low byte.
    logic [ROW_W-1:0]  rows_reg [ROWS];
    logic [ROW_W-1:0]  rows_next [ROWS];
    logic [ROW_W-1:0]  odd_hold_reg, even_hold_reg;
    logic [ROW_W-1:0]  odd_hold_next, even_hold_next;
    logic [1:0]        scan_row_reg, scan_row_next;
    logic [TEXT_W-1:0] text_pos_reg, text_pos_next;
    logic [2:0]        bit_phase_reg, bit_phase_next;
    logic [TEXT_W-1:0] pause_count_reg, pause_count_next;
    logic [TEXT_W-1:0] text_length_reg;
    logic [TEXT_W-1:0] limit;
    logic [TEXT_W-1:0] pause_inc;
    logic              load_glyph;

    logic [1:0]        row_select_reg;
    logic [15:0]       shift_word_reg;
    logic [TEXT_W-1:0] char_index_reg;
    logic              last_reg;

    assign limit = (text_length_reg > TEXT_W'(MAX_TEXT)) ? TEXT_W'(MAX_TEXT) : text_length_reg;
    assign pause_inc = pause_count_reg + TEXT_W'(1);

    always_comb
    begin
        text_pos_next    = text_pos_reg;
        bit_phase_next   = bit_phase_reg;
        pause_count_next = pause_count_reg;
        load_glyph       = 1'b0;
        if (cmd.do_scroll)
        begin
            if (text_pos_reg < limit)
            begin
                if (bit_phase_reg == 3'd7)
                begin
                    load_glyph     = 1'b1;
                    text_pos_next  = text_pos_reg + TEXT_W'(1);
                    bit_phase_next = 3'd0;
                end
                else
                begin
                    bit_phase_next = bit_phase_reg + 3'd1;
                end
            end
            else if (pause_inc >= TEXT_W'(PAUSE_END))
            begin
                text_pos_next    = '0;
                pause_count_next = '0;
            end
            else
            begin
                pause_count_next = pause_inc;
            end
        end
        else if (cmd.do_clear)
        begin
            text_pos_next = '0;
        end
    end

    // Scroll: rows shift one bit toward column 0; ones enter right, or glyph on load.
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            rows_next[r] = rows_reg[r];
            if (cmd.do_clear)
            begin
                rows_next[r] = '1;
            end
            else if (cmd.do_scroll)
            begin
                rows_next[r] = {1'b1, rows_reg[r][ROW_W-1:1]};
                if (load_glyph)
                begin
                    rows_next[r][ROW_W-1 -: 8] = glyph[8*r +: 8];
                end
            end
        end
    end

    always_comb
    begin
        odd_hold_next  = odd_hold_reg;
        even_hold_next = even_hold_reg;
        if (cmd.latch_rows)
        begin
            odd_hold_next  = rows_reg[{scan_row_reg, 1'b1}];
            even_hold_next = rows_reg[{scan_row_reg, 1'b0}];
        end
        else if (cmd.shift_hold)
        begin
            odd_hold_next  = odd_hold_reg >> 8;
            even_hold_next = even_hold_reg >> 8;
        end
    end

    assign scan_row_next = cmd.step_row ? ((scan_row_reg == 2'd3) ? 2'd0 : scan_row_reg + 2'd1)
                                        : scan_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= '1;
            end
            scan_row_reg    <= 2'd3;
            text_pos_reg    <= '0;
            bit_phase_reg   <= '0;
            pause_count_reg <= '0;
            text_length_reg <= '0;
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
            scan_row_reg    <= scan_row_next;
            text_pos_reg    <= text_pos_next;
            bit_phase_reg   <= bit_phase_next;
            pause_count_reg <= pause_count_next;
            if (cfg_we)
            begin
                text_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        odd_hold_reg  <= odd_hold_next;
        even_hold_reg <= even_hold_next;
        if (cmd.load_word)
        begin
            row_select_reg <= scan_row_reg;
            shift_word_reg <= cmd.word_odd ? {8'hFF, even_hold_reg[7:0]}
                                           : {odd_hold_reg[7:0], 8'hFF};
            char_index_reg <= text_pos_reg;
            last_reg       <= cmd.last_word;
        end
        else if (cmd.load_status)
        begin
            row_select_reg <= scan_row_reg;
            shift_word_reg <= '0;
            char_index_reg <= text_pos_reg;
            last_reg       <= 1'b1;
        end
    end

    assign row_select = row_select_reg;
    assign shift_word = shift_word_reg;
    assign char_index = char_index_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

[design/lpss_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpss_ctrl
// Sequencer: takes one transaction, runs the op, drives the result handshake.
// ----------------------------------------------------------------------------
module lpss_ctrl
    import lpss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] op,
    output logic            result_valid,
    input  wire logic       result_stall,
    output dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [WCNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic              out_free;
    logic              accept;
    op_t               op_code;

    assign op_code  = op_t'(op);
    assign out_free = !out_valid_reg || !result_stall;
    assign accept   = item_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_code)
                        OP_REFRESH:
                        begin
                            cmd.latch_rows = 1'b1;
                            word_cnt_next  = '0;
                            state_next     = ST_SCAN;
                        end
                        OP_SCROLL:
                        begin
                            cmd.do_scroll = 1'b1;
                            state_next    = ST_STATUS;
                        end
                        OP_CLEAR:
                        begin
                            cmd.do_clear = 1'b1;
                            state_next   = ST_STATUS;
                        end
                        default:
                        begin
                            state_next = ST_STATUS;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    cmd.load_word  = 1'b1;
                    cmd.word_odd   = word_cnt_reg[0];
                    cmd.shift_hold = word_cnt_reg[0];
                    cmd.last_word  = (word_cnt_reg == WCNT_W'(WORDS - 1));
                    out_valid_next = 1'b1;
                    word_cnt_next  = word_cnt_reg + WCNT_W'(1);
                    if (cmd.last_word)
                    begin
                        cmd.step_row = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    cmd.load_status = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            word_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            word_cnt_reg  <= word_cnt_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start work");

    // result register is never overwritten while it is held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !(cmd.load_word || cmd.load_status))
        else $error("result overwritten while stalled");

    // a refresh always starts at the first word
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_code == OP_REFRESH) |=> (word_cnt_reg == '0))
        else $error("refresh did not start at word zero");

    // leaving the scan happens only on the final word
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_IDLE) |-> cmd.last_word)
        else $error("scan ended early");

endmodule
`default_nettype wire

[design/led_panel_scroll_scan_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// led_panel_scroll_scan_engine
// Frame store, scroll and quarter-scan serializer for an 8x8 byte LED panel.
//
// Input channel: item_valid / item_stall with op and glyph. op 0 refreshes one
// row group, op 1 is a scroll tick (glyph used on a character load), op 2
// blanks the frame and restarts the text, op 3 does nothing.
// Result channel: result_valid / result_stall with row_select, shift_word,
// char_index and last. A refresh yields 16 words, the others one status word.
// Config: cfg_we writes cfg_wdata into the text_length register.
// Timing: a transaction is taken only when the sequencer is idle. The first
// result is registered in the scan or status state entered after the op is
// started; a refresh then emits one word per cycle unless result_stall holds
// it and, like a status op, takes no new transaction before its last word is
// registered. The output register is the only result buffer: while
// result_stall is high a pending word holds and the sequencer waits.
// Reset: frame blank (all ones), row group 3, text position, bit phase and
// pause count zero, text_length zero, no result pending.
// ----------------------------------------------------------------------------
module led_panel_scroll_scan_engine
    import lpss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic [1:0]        op,
    input  wire logic [63:0]       glyph,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [1:0]             row_select,
    output logic [15:0]            shift_word,
    output logic [TEXT_W-1:0]      char_index,
    output logic                   last,
    input  wire logic              cfg_we,
    input  wire logic [TEXT_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;

    lpss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    lpss_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .glyph      (glyph),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .row_select (row_select),
        .shift_word (shift_word),
        .char_index (char_index),
        .last       (last)
    );

endmodule
`default_nettype wire
